// ----- sv/wsd_pkg.sv -----
`default_nettype none
package wsd_pkg;

   typedef enum logic [4:0] {
      PH_HDR0 = 5'b00001,
      PH_HDR1 = 5'b00010,
      PH_EXT  = 5'b00100,
      PH_MASK = 5'b01000,
      PH_DATA = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      FT_TEXT  = 2'd0,
      FT_CLOSE = 2'd1,
      FT_PING  = 2'd2
   } frame_kind_type;

   typedef enum logic [2:0] {
      KIND_MSG   = 3'd0,
      KIND_PONG  = 3'd1,
      KIND_EMPTY = 3'd2,
      KIND_CLOSE = 3'd3,
      KIND_ERROR = 3'd4
   } kind_type;

   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;

   localparam logic [6:0] LEN_16       = 7'd126;
   localparam logic [6:0] LEN_64       = 7'd127;
   localparam logic [6:0] PING_MAX_LEN = 7'd125;
   localparam logic [7:0] PONG_HDR     = 8'h8A;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic       last;
   } result_type;

endpackage
`default_nettype wire

// ----- sv/websocket_frame_deframer_top.sv -----
`default_nettype none
// client websocket frame deframer, one received byte per word on the req_ channel
// req_rx_byte carries the stream; rsp_ words give kind, data_byte and last
// kinds: message byte, pong byte, empty message, close received, protocol error
// each byte is parsed in the cycle it is accepted and its results go straight
// into a four-word result queue, so the first result shows in the cycle after
// throughput is one byte per cycle while req_stall is low; the fourth mask key byte of a ping gives
// two results (pong header), which the queue absorbs while the stream goes on
// req_stall rises only when the queue holds three or more words, i.e. when
// the receiver on rsp_ has stalled for a while
// lengths above 2^LENGTH_BITS - 1 are rejected as protocol errors
// after a close or an error every byte is taken and dropped until reset
// reset (synchronous, active high) empties the queue and returns the parser
// to the first header byte
module websocket_frame_deframer_top #(
   parameter int LENGTH_BITS = 63
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_kind,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_last
);
   import wsd_pkg::*;

   localparam int WIDE_BITS = LENGTH_BITS + 8;

   phase_type              phase_ff, phase_in;
   frame_kind_type         ftype_ff, ftype_in;
   logic [3:0]             ext_left_ff, ext_left_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic                   ovf_ff, ovf_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   halted_ff, halted_in;

   result_type             fifo_ff [4];
   logic [1:0]             wr_ptr_ff, rd_ptr_ff;
   logic [2:0]             count_ff;

   logic                   accept, pop;
   logic [1:0]             push_cnt;
   result_type             res0, res1;
   logic [WIDE_BITS-1:0]   wide;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic                   done;
   logic [7:0]             key_byte;
   logic [7:0]             b;
   result_type             head;

   assign accept    = req_valid && !req_stall;
   assign req_stall = count_ff >= 3'd3;
   assign rsp_valid = count_ff != 3'd0;
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = fifo_ff[rd_ptr_ff];
   assign rsp_kind      = head.kind;
   assign rsp_data_byte = head.data_byte;
   assign rsp_last      = head.last;

   assign b       = req_rx_byte;
   assign wide    = {rem_ff, b};
   assign rem_dec = (rem_ff != '0) ? rem_ff - LENGTH_BITS'(1) : rem_ff;
   assign done    = rem_dec == '0;

   always_comb begin
      unique case (idx_ff)
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         2'd3: key_byte = key_ff[7:0];
         default: key_byte = key_ff[31:24];
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      ftype_in    = ftype_ff;
      ext_left_in = ext_left_ff;
      rem_in      = rem_ff;
      ovf_in      = ovf_ff;
      key_in      = key_ff;
      idx_in      = idx_ff;
      halted_in   = halted_ff;
      push_cnt    = 2'd0;
      res0        = '{kind: KIND_ERROR, data_byte: 8'h00, last: 1'b0};
      res1        = '{kind: KIND_ERROR, data_byte: 8'h00, last: 1'b0};
      if (accept && !halted_ff) begin
         unique case (phase_ff)
            PH_HDR1: begin
               if (!b[7] || (ftype_ff == FT_PING && b[6:0] > PING_MAX_LEN)) begin
                  halted_in = 1'b1;
                  push_cnt  = 2'd1;
               end else begin
                  idx_in = 2'd0;
                  key_in = '0;
                  rem_in = '0;
                  ovf_in = 1'b0;
                  if (b[6:0] == LEN_16) begin
                     ext_left_in = 4'd2;
                     phase_in    = PH_EXT;
                  end else if (b[6:0] == LEN_64) begin
                     ext_left_in = 4'd8;
                     phase_in    = PH_EXT;
                  end else begin
                     rem_in   = {{(LENGTH_BITS-7){1'b0}}, b[6:0]};
                     phase_in = PH_MASK;
                  end
               end
            end
            PH_EXT: begin
               if (ext_left_ff == 4'd8 && b[7]) begin
                  halted_in = 1'b1;
                  push_cnt  = 2'd1;
               end else begin
                  rem_in      = wide[LENGTH_BITS-1:0];
                  ovf_in      = ovf_ff || (wide[WIDE_BITS-1:LENGTH_BITS] != 8'h00);
                  ext_left_in = ext_left_ff - 4'd1;
                  if (ext_left_ff == 4'd1) begin
                     if (ovf_in) begin
                        halted_in = 1'b1;
                        push_cnt  = 2'd1;
                     end else begin
                        phase_in = PH_MASK;
                     end
                  end
               end
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], b};
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  phase_in = PH_DATA;
                  if (rem_ff == '0) begin
                     phase_in = PH_HDR0;
                  end
                  priority if (ftype_ff == FT_PING) begin
                     res0     = '{kind: KIND_PONG, data_byte: PONG_HDR, last: 1'b0};
                     res1     = '{kind: KIND_PONG, data_byte: {1'b0, rem_ff[6:0]},
                                  last: rem_ff == '0};
                     push_cnt = 2'd2;
                  end else if (rem_ff == '0 && ftype_ff == FT_TEXT) begin
                     res0     = '{kind: KIND_EMPTY, data_byte: 8'h00, last: 1'b0};
                     push_cnt = 2'd1;
                  end else if (rem_ff == '0) begin
                     res0      = '{kind: KIND_CLOSE, data_byte: 8'h00, last: 1'b0};
                     push_cnt  = 2'd1;
                     halted_in = 1'b1;
                  end else begin
                     push_cnt = 2'd0;
                  end
               end
            end
            PH_DATA: begin
               idx_in = idx_ff + 2'd1;
               rem_in = rem_dec;
               priority if (ftype_ff == FT_TEXT) begin
                  res0     = '{kind: KIND_MSG, data_byte: b ^ key_byte, last: done};
                  push_cnt = 2'd1;
               end else if (ftype_ff == FT_PING) begin
                  res0     = '{kind: KIND_PONG, data_byte: b ^ key_byte, last: done};
                  push_cnt = 2'd1;
               end else if (done) begin
                  res0      = '{kind: KIND_CLOSE, data_byte: 8'h00, last: 1'b0};
                  push_cnt  = 2'd1;
                  halted_in = 1'b1;
               end else begin
                  push_cnt = 2'd0;
               end
               if (done) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               // first header byte, also taken for any stray phase code
               if (!b[7] || b[6:4] != 3'b000) begin
                  halted_in = 1'b1;
                  push_cnt  = 2'd1;
               end else begin
                  unique case (b[3:0])
                     OP_TEXT: begin
                        ftype_in = FT_TEXT;
                        phase_in = PH_HDR1;
                     end
                     OP_CLOSE: begin
                        ftype_in = FT_CLOSE;
                        phase_in = PH_HDR1;
                     end
                     OP_PING: begin
                        ftype_in = FT_PING;
                        phase_in = PH_HDR1;
                     end
                     default: begin
                        phase_in  = PH_HDR0;
                        halted_in = 1'b1;
                        push_cnt  = 2'd1;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         ftype_ff    <= FT_TEXT;
         ext_left_ff <= 4'd0;
         rem_ff      <= '0;
         ovf_ff      <= 1'b0;
         key_ff      <= '0;
         idx_ff      <= 2'd0;
         halted_ff   <= 1'b0;
         wr_ptr_ff   <= 2'd0;
         rd_ptr_ff   <= 2'd0;
         count_ff    <= 3'd0;
      end else begin
         phase_ff    <= phase_in;
         ftype_ff    <= ftype_in;
         ext_left_ff <= ext_left_in;
         rem_ff      <= rem_in;
         ovf_ff      <= ovf_in;
         key_ff      <= key_in;
         idx_ff      <= idx_in;
         halted_ff   <= halted_in;
         wr_ptr_ff   <= wr_ptr_ff + push_cnt;
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + {1'b0, push_cnt} - {2'b00, pop};
      end
   end

   // result queue payload
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (push_cnt == 2'd2) begin
         fifo_ff[wr_ptr_ff + 2'd1] <= res1;
      end
   end

endmodule
`default_nettype wire
